/* rtl/cidr_pkg.sv */
// Shared types and constants for the IPv4 CIDR text parser.
`timescale 1ns / 1ps

package cidr_pkg;

    // ASCII codes the parser recognizes.
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field limits and saturation points.
    localparam logic [9:0] OCTET_MAX  = 10'd255;
    localparam logic [9:0] PREFIX_MAX = 10'd32;
    localparam logic [9:0] FIELD_SAT  = 10'd1023;
    localparam logic [2:0] COUNT_SAT  = 3'd4;
    localparam logic [2:0] COUNT_MAX  = 3'd3;
    localparam logic [1:0] LAST_OCTET = 2'd3;

    // Default depth of the queue between classifier and parser.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ADDR   = 2'd1,
        ST_BAD_PREFIX = 2'd2,
        ST_NO_SLASH   = 2'd3
    } status_t;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic       is_digit;
        logic       is_dot;
        logic       is_slash;
        logic [3:0] digit;
        logic       last;
    } char_class_t;

    localparam int CLASS_W = $bits(char_class_t);

    // One parse result.
    typedef struct packed {
        status_t     status;
        logic [31:0] address;
        logic [5:0]  prefix_len;
    } result_t;

endpackage

/* rtl/cidr_front.sv */
// Character classifier: turns an incoming ASCII beat into a classified item.
`timescale 1ns / 1ps

module cidr_front (
    input  logic [7:0]          character,
    input  logic                last_char,
    output cidr_pkg::char_class_t item
);

    logic [7:0] offset;

    // Digit range check and digit value from the ASCII offset.
    always_comb begin
        offset        = character - cidr_pkg::CH_ZERO;
        item.is_digit = (character >= cidr_pkg::CH_ZERO) && (character <= cidr_pkg::CH_NINE);
        item.is_dot   = (character == cidr_pkg::CH_DOT);
        item.is_slash = (character == cidr_pkg::CH_SLASH);
        item.digit    = offset[3:0];
        item.last     = last_char;
    end

endmodule

/* rtl/cidr_queue.sv */
// Short queue that decouples the classifier from the parser.
`timescale 1ns / 1ps

module cidr_queue #(
    parameter int DEPTH = cidr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cidr_pkg::char_class_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output cidr_pkg::char_class_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cidr_pkg::char_class_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // Pointer wrap and occupancy tracking.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    // A pop with no push empties one slot.
    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop did not drain a slot");

endmodule

/* rtl/cidr_back.sv */
// Parser back end: octet and prefix accumulation, error tracking, result register.
`timescale 1ns / 1ps

module cidr_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  require_prefix,
    input  logic                  item_valid,
    input  cidr_pkg::char_class_t item,
    output logic                  item_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cidr_pkg::result_t     out_result
);

    logic        in_prefix_reg,   in_prefix_next;
    logic [1:0]  octet_index_reg, octet_index_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [9:0]  field_value_reg, field_value_next;
    logic [31:0] address_shift_reg, address_shift_next;
    logic        address_bad_reg, address_bad_next;
    logic        prefix_bad_reg,  prefix_bad_next;
    logic        out_valid_reg,   out_valid_next;
    cidr_pkg::result_t out_result_reg, out_result_next;

    logic [13:0] acc;
    logic [9:0]  digit_value;
    logic [2:0]  digit_count_inc;
    logic        close_bad;
    logic        plain_bad;
    logic [31:0] mask;

    // An octet field is bad when empty, too long or above 255.
    function automatic logic octet_bad(input logic [2:0] dc, input logic [9:0] fv);
        octet_bad = (dc == 3'd0) || (dc > cidr_pkg::COUNT_MAX) || (fv > cidr_pkg::OCTET_MAX);
    endfunction

    // A last item waits until the result register is free.
    assign item_pop   = item_valid && (!item.last || !out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // Decimal accumulate with saturation.
    always_comb begin
        acc             = 14'(field_value_reg) * 14'd10 + 14'(item.digit);
        digit_value     = (acc > 14'(cidr_pkg::FIELD_SAT)) ? cidr_pkg::FIELD_SAT : acc[9:0];
        digit_count_inc = (digit_count_reg < cidr_pkg::COUNT_SAT) ?
                          digit_count_reg + 3'd1 : digit_count_reg;
        close_bad       = octet_bad(digit_count_reg, field_value_reg);
    end

    // One character step of the parser.
    always_comb begin
        in_prefix_next     = in_prefix_reg;
        octet_index_next   = octet_index_reg;
        digit_count_next   = digit_count_reg;
        field_value_next   = field_value_reg;
        address_shift_next = address_shift_reg;
        address_bad_next   = address_bad_reg;
        prefix_bad_next    = prefix_bad_reg;
        if (in_prefix_reg) begin
            if (item.is_digit) begin
                field_value_next = digit_value;
                digit_count_next = digit_count_inc;
            end else begin
                prefix_bad_next = 1'b1;
            end
        end else if (item.is_digit) begin
            field_value_next = digit_value;
            digit_count_next = digit_count_inc;
        end else if (item.is_dot) begin
            if (octet_index_reg == cidr_pkg::LAST_OCTET) begin
                address_bad_next = 1'b1;
            end else begin
                octet_index_next = octet_index_reg + 2'd1;
            end
            address_bad_next   = address_bad_next | close_bad;
            address_shift_next = {address_shift_reg[23:0], field_value_reg[7:0]};
            digit_count_next   = '0;
            field_value_next   = '0;
        end else if (item.is_slash && require_prefix) begin
            address_bad_next   = address_bad_reg | close_bad
                               | (octet_index_reg != cidr_pkg::LAST_OCTET);
            address_shift_next = {address_shift_reg[23:0], field_value_reg[7:0]};
            digit_count_next   = '0;
            field_value_next   = '0;
            in_prefix_next     = 1'b1;
        end else begin
            address_bad_next = 1'b1;
        end
    end

    // Result formation from the state after this character.
    always_comb begin
        mask      = ~(32'hFFFF_FFFF >> field_value_next[5:0]);
        plain_bad = address_bad_next || (octet_index_next != cidr_pkg::LAST_OCTET)
                  || octet_bad(digit_count_next, field_value_next);
        out_result_next.status     = cidr_pkg::ST_OK;
        out_result_next.address    = '0;
        out_result_next.prefix_len = '0;
        if (require_prefix) begin
            if (!in_prefix_next) begin
                out_result_next.status = cidr_pkg::ST_NO_SLASH;
            end else if (address_bad_next) begin
                out_result_next.status = cidr_pkg::ST_BAD_ADDR;
            end else if (prefix_bad_next || (digit_count_next == 3'd0)
                         || (digit_count_next > cidr_pkg::COUNT_MAX)
                         || (field_value_next > cidr_pkg::PREFIX_MAX)) begin
                out_result_next.status = cidr_pkg::ST_BAD_PREFIX;
            end else begin
                out_result_next.address    = address_shift_next & mask;
                out_result_next.prefix_len = field_value_next[5:0];
            end
        end else if (plain_bad) begin
            out_result_next.status = cidr_pkg::ST_BAD_ADDR;
        end else begin
            out_result_next.address = {address_shift_next[23:0], field_value_next[7:0]};
        end
    end

    // Output beat handshake.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_pop && item.last) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Parser state: cleared after the last character of each string.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_prefix_reg     <= 1'b0;
            octet_index_reg   <= '0;
            digit_count_reg   <= '0;
            field_value_reg   <= '0;
            address_shift_reg <= '0;
            address_bad_reg   <= 1'b0;
            prefix_bad_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_pop) begin
                if (item.last) begin
                    in_prefix_reg     <= 1'b0;
                    octet_index_reg   <= '0;
                    digit_count_reg   <= '0;
                    field_value_reg   <= '0;
                    address_shift_reg <= '0;
                    address_bad_reg   <= 1'b0;
                    prefix_bad_reg    <= 1'b0;
                end else begin
                    in_prefix_reg     <= in_prefix_next;
                    octet_index_reg   <= octet_index_next;
                    digit_count_reg   <= digit_count_next;
                    field_value_reg   <= field_value_next;
                    address_shift_reg <= address_shift_next;
                    address_bad_reg   <= address_bad_next;
                    prefix_bad_reg    <= prefix_bad_next;
                end
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (item_pop && item.last) begin
            out_result_reg <= out_result_next;
        end
    end

    // A failed parse never reports an address or a prefix.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_result_reg.status != cidr_pkg::ST_OK))
        |-> ((out_result_reg.address == '0) && (out_result_reg.prefix_len == '0)))
        else $error("error result carries address or prefix bits");

    // The digit counter saturates at four.
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= cidr_pkg::COUNT_SAT)
        else $error("digit counter above saturation");

    // A pending result held back by the consumer is not overwritten.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_result_reg)))
        else $error("pending result lost or changed");

endmodule

/* rtl/ipv4_cidr_text_parser.sv */
// Top level of the IPv4 dotted-quad and CIDR text parser.
`timescale 1ns / 1ps

// The parser takes one ASCII character per beat on the slave side and
// sustains one character per clock cycle. Each character is classified on
// entry and placed in a small queue (QUEUE_DEPTH entries); the parser reads
// one queued character per cycle, doing a single multiply-by-ten add and a
// few compares, so the parser step is what fixes the rate. A taken character
// is written into the queue storage and read by the parser from there, and the
// result of a string is registered and shown on the master side in the cycle
// after its last character is parsed. The input only stalls when the queue
// fills, which happens when a finished result is not taken and a further
// string's last character arrives behind it. The prefix mode register is
// written through cfg_wr_en and cfg_wr_data and must only change while the
// block is idle.

module ipv4_cidr_text_parser #(
    parameter int QUEUE_DEPTH = cidr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: bit 0 selects address/prefix parsing.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Input characters.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] character
    input  logic        s_tlast,    // last_char
    // Parse results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [1:0] status, [33:2] address, [39:34] prefix_len
);

    logic                  require_prefix_reg;
    logic                  queue_full;
    logic                  queue_not_empty;
    logic                  queue_pop;
    cidr_pkg::char_class_t front_item;
    cidr_pkg::char_class_t back_item;
    cidr_pkg::result_t     result;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            require_prefix_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            require_prefix_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !queue_full;

    cidr_front u_front (
        .character (s_tdata),
        .last_char (s_tlast),
        .item      (front_item)
    );

    cidr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_data  (back_item)
    );

    cidr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .require_prefix (require_prefix_reg),
        .item_valid     (queue_not_empty),
        .item           (back_item),
        .item_pop       (queue_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_result     (result)
    );

    // Result beat packing, first field in the lowest bits.
    assign m_tdata = {result.prefix_len, result.address, result.status};

endmodule
